@@ hw/rtl/mrsp_pkg.sv @@
// Package for the model record stream parser: section codes, record kinds,
// status codes and packed record type. No dependencies.
package mrsp_pkg;

  localparam logic [4:0] SEC_FLAGS   = 5'd0;
  localparam logic [4:0] SEC_BOX     = 5'd1;
  localparam logic [4:0] SEC_SCRSZ   = 5'd2;
  localparam logic [4:0] SEC_SCRSKIP = 5'd3;
  localparam logic [4:0] SEC_VCOUNT  = 5'd4;
  localparam logic [4:0] SEC_VERT    = 5'd5;
  localparam logic [4:0] SEC_GCOUNT  = 5'd6;
  localparam logic [4:0] SEC_GORDER  = 5'd7;
  localparam logic [4:0] SEC_GENTRY  = 5'd8;
  localparam logic [4:0] SEC_PCOUNT  = 5'd9;
  localparam logic [4:0] SEC_PTYPE   = 5'd10;
  localparam logic [4:0] SEC_PHDR    = 5'd11;
  localparam logic [4:0] SEC_PSIZE   = 5'd12;
  localparam logic [4:0] SEC_PREF    = 5'd13;
  localparam logic [4:0] SEC_PU      = 5'd14;
  localparam logic [4:0] SEC_PV      = 5'd15;
  localparam logic [4:0] SEC_DONE    = 5'd16;

  localparam logic [3:0] REC_FLAGS   = 4'd0;
  localparam logic [3:0] REC_VCOUNT  = 4'd1;
  localparam logic [3:0] REC_VCOORD  = 4'd2;
  localparam logic [3:0] REC_GCOUNT  = 4'd3;
  localparam logic [3:0] REC_GORDER  = 4'd4;
  localparam logic [3:0] REC_GFIELD  = 4'd5;
  localparam logic [3:0] REC_PCOUNT  = 4'd6;
  localparam logic [3:0] REC_PHDR    = 4'd7;
  localparam logic [3:0] REC_PREF    = 4'd8;
  localparam logic [3:0] REC_U       = 4'd9;
  localparam logic [3:0] REC_V       = 4'd10;
  localparam logic [3:0] REC_END     = 4'd11;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_VERTS    = 3'd3;
  localparam logic [2:0] ST_GROUPS   = 3'd4;
  localparam logic [2:0] ST_PRIM     = 3'd5;
  localparam logic [2:0] ST_UNKNOWN  = 3'd6;

  localparam logic [15:0] FLAG_ANIM = 16'h0002;
  localparam logic [15:0] FLAG_OPT  = 16'h0008;
  localparam int MIN_BYTES = 16;
  localparam int BOX_BYTES = 12;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] entity;
    logic [7:0]  comp;
    logic [16:0] value;
    logic [2:0]  status;
    logic        eop;
  } rec_t;

  // record word packed from field 0 in the low bits, padded to 56 bits
  function automatic logic [55:0] pack_rec(rec_t r);
    return {7'd0, r.eop, r.status, r.value, r.comp, r.entity, r.kind};
  endfunction

endpackage

@@ hw/rtl/mrsp_out_queue.sv @@
// Four-entry result queue between the parse step and the output stream.
// Depends on mrsp_pkg.
module mrsp_out_queue
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push0,
  input  logic        push1,
  input  rec_t        rec0,
  input  rec_t        rec1,
  output logic        space2,
  output logic        tvalid,
  input  logic        tready,
  output logic [55:0] tdata
);
  rec_t       q [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] n_push;

  assign pop    = tvalid && tready;
  assign tvalid = count != 3'd0;
  assign tdata  = pack_rec(q[rd_ptr]);
  assign n_push = {2'd0, push0} + {2'd0, push1};
  // two free entries remain after this cycle's pushes, ignoring any pop
  assign space2 = (count + n_push) <= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push0 && push1) begin
        q[wr_ptr]        <= rec0;
        q[wr_ptr + 2'd1] <= rec1;
      end else if (push0) begin
        q[wr_ptr] <= rec0;
      end else if (push1) begin
        q[wr_ptr] <= rec1;
      end
      wr_ptr <= wr_ptr + n_push[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + n_push - {2'd0, pop};
    end
  end
endmodule

@@ hw/rtl/model_record_stream_parser.sv @@
// Top level of the model record stream parser: byte input register,
// one-step field decoder and result queue. Depends on mrsp_pkg, mrsp_out_queue.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata[7:0] data_byte, tlast last_byte
//  m_axis  | out | m_axis_tvalid/tready   | tdata 56b record, tlast end_of_parse
//
// One byte per clock: each accepted byte is decoded in the cycle after
// acceptance and its zero, one or two records enter a four-entry queue.
// The input side stalls when the queue, counting the records of the byte
// in decode, has fewer than two free entries.
// Synchronous reset returns the parser to the flags word of a new file.
module model_record_stream_parser
  import mrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [3:0] record_kind, [19:4] entity_index,
                                      // [27:20] component, [44:28] field_value,
                                      // [47:45] status, [48] end_of_parse
  output logic        m_axis_tlast    // end_of_parse
);
  logic        in_v;
  logic [7:0]  in_b;
  logic        in_last;
  logic        space2;

  logic [4:0]  section, section_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic        byte_phase, byte_phase_next;
  logic [15:0] file_flags, file_flags_next;
  logic [4:0]  bytes_seen, bytes_seen_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [15:0] items_remaining, items_remaining_next;
  logic [15:0] group_total, group_total_next;
  logic [15:0] item_number, item_number_next;
  logic [3:0]  field_number, field_number_next;
  logic [3:0]  prim_kind, prim_kind_next;
  logic [7:0]  prim_vertices, prim_vertices_next;
  logic [7:0]  vertex_slot, vertex_slot_next;
  logic        parse_ended, parse_ended_next;

  logic        push0, push1;
  rec_t        rec0, rec1;

  // space2 already counts the records of the byte in decode
  assign s_axis_tready = space2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= s_axis_tvalid && s_axis_tready;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_b    <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // word helpers
  logic [15:0] w;
  logic [16:0] sw;
  logic        word_sec;
  logic        opt;
  logic        take;
  logic [15:0] neg_mag, div6_mag, ord_div;
  logic [16:0] gdiv6;
  logic [15:0] ref_div6;
  logic [7:0]  slot_inc;
  logic [2:0]  end_st;
  logic [15:0] items_dec;

  function automatic logic [15:0] div6(logic [15:0] v);
    logic [32:0] p;
    begin
      // floor(v * 43691 / 2^18) equals v / 6 for all 16-bit v
      p = {17'd0, v} * 33'd43691;
      return p[33-1 -: 15] == 15'd0 ? 16'd0 : {2'd0, p[31:18]};
    end
  endfunction

  function automatic logic [15:0] div24(logic [15:0] v);
    logic [31:0] p;
    begin
      // v / 24 = (v >> 3) / 3 ; floor(x * 43691 / 2^17) is x/3 for x < 2^13
      p = {19'd0, v[15:3]} * 32'd43691;
      return {4'd0, p[28:17]};
    end
  endfunction

  assign w   = {in_b, held_low_byte};
  assign sw  = {w[15], w};
  assign opt = (file_flags & FLAG_OPT) != 16'd0;
  assign take = in_v && !parse_ended;
  assign neg_mag  = w[15] ? (~w + 16'd1) : w;
  assign div6_mag = div6(neg_mag);
  assign gdiv6    = w[15] ? (~{1'b0, div6_mag} + 17'd1) : {1'b0, div6_mag};
  assign ref_div6 = div6(w);
  assign ord_div  = opt ? div24(w) : {4'd0, w[15:4]};
  assign slot_inc = vertex_slot + 8'd1;
  assign items_dec = items_remaining - 16'd1;

  always_comb begin
    case (section)
      SEC_FLAGS, SEC_SCRSZ, SEC_VCOUNT, SEC_VERT, SEC_GCOUNT, SEC_GORDER,
      SEC_PCOUNT, SEC_PSIZE, SEC_PREF: word_sec = 1'b1;
      SEC_GENTRY: word_sec = field_number != 4'd3 && field_number != 4'd4;
      default: word_sec = 1'b0;
    endcase
  end

  always_comb begin
    rec0 = '0;
    rec1 = '0;
    push0 = 1'b0;
    push1 = 1'b0;
    section_next = section;
    held_low_byte_next = held_low_byte;
    byte_phase_next = byte_phase;
    file_flags_next = file_flags;
    bytes_seen_next = bytes_seen;
    skip_remaining_next = skip_remaining;
    items_remaining_next = items_remaining;
    group_total_next = group_total;
    item_number_next = item_number;
    field_number_next = field_number;
    prim_kind_next = prim_kind;
    prim_vertices_next = prim_vertices;
    vertex_slot_next = vertex_slot;
    parse_ended_next = parse_ended;
    end_st = ST_OK;

    if (in_v) begin
      if (bytes_seen < 5'(MIN_BYTES)) bytes_seen_next = bytes_seen + 5'd1;
    end

    if (take && section != SEC_DONE) begin
      if (word_sec && !byte_phase) begin
        held_low_byte_next = in_b;
        byte_phase_next = 1'b1;
      end else begin
        if (word_sec) byte_phase_next = 1'b0;
        push0 = 1'b1;
        case (section)
          SEC_FLAGS: begin
            file_flags_next = w;
            rec0.kind = REC_FLAGS;
            rec0.value = {1'b0, w};
            skip_remaining_next = 16'(BOX_BYTES);
            section_next = SEC_BOX;
          end
          SEC_BOX: begin
            push0 = 1'b0;
            skip_remaining_next = skip_remaining - 16'd1;
            if (skip_remaining == 16'd1) section_next = SEC_SCRSZ;
          end
          SEC_SCRSZ: begin
            push0 = 1'b0;
            skip_remaining_next = w;
            section_next = w == 16'd0 ? SEC_VCOUNT : SEC_SCRSKIP;
          end
          SEC_SCRSKIP: begin
            push0 = 1'b0;
            skip_remaining_next = skip_remaining - 16'd1;
            if (skip_remaining == 16'd1) section_next = SEC_VCOUNT;
          end
          SEC_VCOUNT: begin
            rec0.kind = REC_VCOUNT;
            rec0.value = {1'b0, w};
            items_remaining_next = w;
            item_number_next = '0;
            field_number_next = '0;
            if (w == 16'd0)
              section_next = (file_flags & FLAG_ANIM) != 16'd0 ? SEC_GCOUNT : SEC_PCOUNT;
            else section_next = SEC_VERT;
          end
          SEC_VERT: begin
            rec0.kind = REC_VCOORD;
            rec0.entity = item_number;
            rec0.comp = {4'd0, field_number};
            rec0.value = sw;
            if (field_number >= 4'd2) begin
              field_number_next = '0;
              item_number_next = item_number + 16'd1;
              items_remaining_next = items_dec;
              if (items_dec == 16'd0)
                section_next = (file_flags & FLAG_ANIM) != 16'd0 ? SEC_GCOUNT : SEC_PCOUNT;
            end else begin
              field_number_next = field_number + 4'd1;
            end
          end
          SEC_GCOUNT: begin
            rec0.kind = REC_GCOUNT;
            rec0.value = {1'b0, w};
            group_total_next = w;
            items_remaining_next = w;
            item_number_next = '0;
            section_next = w == 16'd0 ? SEC_PCOUNT : SEC_GORDER;
          end
          SEC_GORDER: begin
            rec0.kind = REC_GORDER;
            rec0.entity = item_number;
            rec0.value = {1'b0, ord_div};
            item_number_next = item_number + 16'd1;
            items_remaining_next = items_dec;
            if (items_dec == 16'd0) begin
              item_number_next = '0;
              items_remaining_next = group_total;
              field_number_next = '0;
              section_next = SEC_GENTRY;
            end
          end
          SEC_GENTRY: begin
            rec0.kind = REC_GFIELD;
            rec0.entity = item_number;
            rec0.comp = {4'd0, field_number};
            if (field_number == 4'd3 || field_number == 4'd4)
              rec0.value = {{9{in_b[7]}}, in_b};
            else if (field_number == 4'd0 || field_number == 4'd2)
              rec0.value = gdiv6;
            else if (field_number <= 4'd11)
              rec0.value = sw;
            else push0 = 1'b0;
            if (field_number >= (opt ? 4'd12 : 4'd8)) begin
              field_number_next = '0;
              item_number_next = item_number + 16'd1;
              items_remaining_next = items_dec;
              if (items_dec == 16'd0) section_next = SEC_PCOUNT;
            end else begin
              field_number_next = field_number + 4'd1;
            end
          end
          SEC_PCOUNT: begin
            rec0.kind = REC_PCOUNT;
            rec0.value = {1'b0, w};
            items_remaining_next = w;
            item_number_next = '0;
            section_next = w == 16'd0 ? SEC_DONE : SEC_PTYPE;
          end
          SEC_PTYPE: begin
            if (in_b > 8'd10) begin
              rec0.kind = REC_END;
              rec0.entity = item_number;
              rec0.status = ST_UNKNOWN;
              rec0.eop = 1'b1;
              parse_ended_next = 1'b1;
              section_next = SEC_DONE;
            end else begin
              prim_kind_next = in_b[3:0];
              rec0.kind = REC_PHDR;
              rec0.entity = item_number;
              rec0.value = {9'd0, in_b};
              prim_vertices_next = in_b == 8'd0 ? 8'd2 : 8'd1;
              field_number_next = 4'd1;
              section_next = SEC_PHDR;
            end
          end
          SEC_PHDR: begin
            rec0.kind = REC_PHDR;
            rec0.entity = item_number;
            rec0.comp = {4'd0, field_number};
            rec0.value = {9'd0, in_b};
            if ((prim_kind == 4'd1 || prim_kind >= 4'd8) && field_number == 4'd1)
              prim_vertices_next = in_b;
            field_number_next = field_number + 4'd1;
            if (field_number >= 4'd3) begin
              if (prim_kind >= 4'd3 && prim_kind <= 4'd5) section_next = SEC_PSIZE;
              else begin
                vertex_slot_next = '0;
                if (prim_vertices_next == 8'd0) begin
                  item_number_next = item_number + 16'd1;
                  items_remaining_next = items_dec;
                  section_next = items_dec == 16'd0 ? SEC_DONE : SEC_PTYPE;
                end else section_next = SEC_PREF;
              end
            end
          end
          SEC_PSIZE: begin
            rec0.kind = REC_PHDR;
            rec0.entity = item_number;
            rec0.comp = 8'd4;
            rec0.value = {1'b0, w};
            vertex_slot_next = '0;
            if (prim_vertices == 8'd0) begin
              item_number_next = item_number + 16'd1;
              items_remaining_next = items_dec;
              section_next = items_dec == 16'd0 ? SEC_DONE : SEC_PTYPE;
            end else section_next = SEC_PREF;
          end
          SEC_PREF: begin
            rec0.kind = REC_PREF;
            rec0.entity = item_number;
            rec0.comp = vertex_slot;
            rec0.value = {1'b0, ref_div6};
            vertex_slot_next = slot_inc;
            if (slot_inc >= prim_vertices) begin
              if (prim_kind == 4'd9 || prim_kind == 4'd10) begin
                vertex_slot_next = '0;
                section_next = SEC_PU;
              end else begin
                item_number_next = item_number + 16'd1;
                items_remaining_next = items_dec;
                section_next = items_dec == 16'd0 ? SEC_DONE : SEC_PTYPE;
              end
            end
          end
          SEC_PU: begin
            rec0.kind = REC_U;
            rec0.entity = item_number;
            rec0.comp = vertex_slot;
            rec0.value = {9'd0, in_b};
            section_next = SEC_PV;
          end
          SEC_PV: begin
            rec0.kind = REC_V;
            rec0.entity = item_number;
            rec0.comp = vertex_slot;
            rec0.value = {9'd0, in_b};
            vertex_slot_next = slot_inc;
            if (slot_inc >= prim_vertices) begin
              item_number_next = item_number + 16'd1;
              items_remaining_next = items_dec;
              section_next = items_dec == 16'd0 ? SEC_DONE : SEC_PTYPE;
            end else section_next = SEC_PU;
          end
          default: begin
            push0 = 1'b0;
            section_next = SEC_DONE;
          end
        endcase
      end
    end

    // end status from the state after this byte
    if (bytes_seen_next < 5'(MIN_BYTES)) end_st = ST_SHORT;
    else if (section_next <= SEC_SCRSKIP) end_st = ST_HEADER;
    else if (section_next <= SEC_VERT) end_st = ST_VERTS;
    else if (section_next <= SEC_GENTRY) end_st = ST_GROUPS;
    else if (section_next == SEC_PCOUNT || section_next == SEC_DONE) end_st = ST_OK;
    else end_st = ST_PRIM;

    if (in_v && in_last) begin
      if (!parse_ended && !parse_ended_next) begin
        rec1.kind = REC_END;
        rec1.entity = item_number_next;
        rec1.status = end_st;
        rec1.eop = 1'b1;
        push1 = 1'b1;
      end
      section_next = SEC_FLAGS;
      held_low_byte_next = '0;
      byte_phase_next = 1'b0;
      file_flags_next = '0;
      bytes_seen_next = '0;
      skip_remaining_next = '0;
      items_remaining_next = '0;
      group_total_next = '0;
      item_number_next = '0;
      field_number_next = '0;
      prim_kind_next = '0;
      prim_vertices_next = '0;
      vertex_slot_next = '0;
      parse_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section <= SEC_FLAGS;
      held_low_byte <= '0;
      byte_phase <= 1'b0;
      file_flags <= '0;
      bytes_seen <= '0;
      skip_remaining <= '0;
      items_remaining <= '0;
      group_total <= '0;
      item_number <= '0;
      field_number <= '0;
      prim_kind <= '0;
      prim_vertices <= '0;
      vertex_slot <= '0;
      parse_ended <= 1'b0;
    end else begin
      section <= section_next;
      held_low_byte <= held_low_byte_next;
      byte_phase <= byte_phase_next;
      file_flags <= file_flags_next;
      bytes_seen <= bytes_seen_next;
      skip_remaining <= skip_remaining_next;
      items_remaining <= items_remaining_next;
      group_total <= group_total_next;
      item_number <= item_number_next;
      field_number <= field_number_next;
      prim_kind <= prim_kind_next;
      prim_vertices <= prim_vertices_next;
      vertex_slot <= vertex_slot_next;
      parse_ended <= parse_ended_next;
    end
  end

  mrsp_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push0  (push0),
    .push1  (push1),
    .rec0   (rec0),
    .rec1   (rec1),
    .space2 (space2),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (m_axis_tdata)
  );

  assign m_axis_tlast = m_axis_tdata[48];

endmodule

@@ hw/rtl/mrsp_checker.sv @@
// Port-level checker for model_record_stream_parser, bound to the top level.
// Depends on mrsp_pkg.
module mrsp_checker
  import mrsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped while stalled");

  a_tlast_eop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tlast == m_axis_tdata[48])
    else $error("tlast does not follow end_of_parse");

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == REC_END)
    else $error("end marker on a field record");

  a_field_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[47:45] == ST_OK)
    else $error("status set on a field record");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");
endmodule

bind model_record_stream_parser mrsp_checker u_mrsp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
